// ----- hdl/tcw_pkg.sv -----
// Shared types and constants for the text console writer.
// Holds port widths, function and character codes, the controller state type
// and the command/status structs that join the controller and the datapath.
package tcw_pkg;

  // Fixed port widths
  localparam int FUNC_W    = 2;
  localparam int CHAR_W    = 8;
  localparam int INDEX_W   = 11;
  localparam int COL_OUT_W = 7;
  localparam int ROW_OUT_W = 5;
  localparam int LOC_W     = 11;
  localparam int ATTR_W    = 8;
  localparam int CELL_W    = ATTR_W + CHAR_W;

  // Request function codes (code 3 is a no-op)
  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUT   = 2'd0,
    FUNC_CLEAR = 2'd1,
    FUNC_READ  = 2'd2
  } func_t;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_BACKSPACE  = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB        = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF         = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR         = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE      = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PRINT_LAST = 8'h7F;

  // Attribute after reset: white on black
  localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h0F;

  // Controller states
  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_DISPATCH,
    ST_PUT,
    ST_COPY,
    ST_DRAIN,
    ST_FILL,
    ST_DONE
  } state_t;

  // Datapath operations
  typedef enum logic [3:0] {
    DP_NOP,
    DP_CAPTURE,
    DP_PUT,
    DP_READ,
    DP_COPY,
    DP_DRAIN,
    DP_FILL,
    DP_INIT_FILL,
    DP_RESULT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   home_cursor;
  } tcw_cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              put_scroll;
    logic              copy_last;
    logic              sweep_last;
    logic              out_free;
  } tcw_status_t;

endpackage

// ----- hdl/text_console_writer.sv -----
// Put: a request is accepted, dispatched, executed and its result loaded; read
// and no-op requests go from dispatch straight to the result load. Clear writes
// all SCREEN_COLS*SCREEN_ROWS cells, one write per cycle. A put that scrolls adds
// a copy of (ROWS-1)*COLS cells (one read and one write per cycle), a drain and
// COLS blank writes. Reset (rst, synchronous) homes the cursor, sets the
// attribute to 0x0F and clears all SCREEN_COLS*SCREEN_ROWS cells with in_stall high.
module text_console_writer import tcw_pkg::*; #(
  parameter int SCREEN_COLS = 80,
  parameter int SCREEN_ROWS = 25,
  parameter int TAB_WIDTH   = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [ATTR_W-1:0]    cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [FUNC_W-1:0]    func,
  input  logic [CHAR_W-1:0]    char_code,
  input  logic [INDEX_W-1:0]   cell_index,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [COL_OUT_W-1:0] cursor_column,
  output logic [ROW_OUT_W-1:0] cursor_row_out,
  output logic [LOC_W-1:0]     cursor_location,
  output logic [CELL_W-1:0]    cell_word
);

  tcw_cmd_t    cmd;
  tcw_status_t status;

  // Sequencer
  tcw_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Screen memory, cursor and output register
  tcw_datapath #(
    .SCREEN_COLS (SCREEN_COLS),
    .SCREEN_ROWS (SCREEN_ROWS),
    .TAB_WIDTH   (TAB_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .func            (func),
    .char_code       (char_code),
    .cell_index      (cell_index),
    .cmd             (cmd),
    .status          (status),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .cursor_column   (cursor_column),
    .cursor_row_out  (cursor_row_out),
    .cursor_location (cursor_location),
    .cell_word       (cell_word)
  );

endmodule

// ----- hdl/tcw_datapath.sv -----
// Datapath of the text console writer: screen memory, cursor, attribute
// register, sweep counter for clear/scroll and the output register.
// Depends on tcw_pkg; driven by tcw_controller through tcw_cmd_t.
module tcw_datapath import tcw_pkg::*; #(
  parameter int SCREEN_COLS = 80,
  parameter int SCREEN_ROWS = 25,
  parameter int TAB_WIDTH   = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [ATTR_W-1:0]    cfg_wdata,
  input  logic [FUNC_W-1:0]    func,
  input  logic [CHAR_W-1:0]    char_code,
  input  logic [INDEX_W-1:0]   cell_index,
  input  tcw_cmd_t             cmd,
  output tcw_status_t          status,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [COL_OUT_W-1:0] cursor_column,
  output logic [ROW_OUT_W-1:0] cursor_row_out,
  output logic [LOC_W-1:0]     cursor_location,
  output logic [CELL_W-1:0]    cell_word
);

  localparam int CELL_COUNT = SCREEN_COLS * SCREEN_ROWS;
  localparam int COPY_COUNT = (SCREEN_ROWS - 1) * SCREEN_COLS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int COL_W      = $clog2(SCREEN_COLS);
  localparam int ROW_W      = $clog2(SCREEN_ROWS);
  localparam int COLX_W     = $clog2(SCREEN_COLS + TAB_WIDTH);
  localparam int NUM_STOPS  = (SCREEN_COLS + TAB_WIDTH - 1) / TAB_WIDTH;
  localparam int IDX_W      = ((ADDR_W > INDEX_W) ? ADDR_W : INDEX_W) + 1;

  // Registers
  logic [ATTR_W-1:0]  text_attribute;
  logic [COL_W-1:0]   column;
  logic [ROW_W-1:0]   row;
  logic [FUNC_W-1:0]  func_q;
  logic [CHAR_W-1:0]  char_q;
  logic [INDEX_W-1:0] idx_q;
  logic [ADDR_W-1:0]  sweep_addr;
  logic [ADDR_W-1:0]  copy_waddr;
  logic               copy_pend;
  logic [CELL_W-1:0]  rd_data;
  logic [CELL_W-1:0]  mem [CELL_COUNT];

  // Combinational
  logic [ADDR_W-1:0] pos;
  logic [IDX_W-1:0]  idx_ext;
  logic              idx_ok;
  logic              printable;
  logic [COLX_W-1:0] tab_stop;
  logic [COLX_W-1:0] col_x;
  logic              line_feed;
  logic              put_write;
  logic              wrap;
  logic              row_adv;
  logic              put_scroll;
  logic [COL_W-1:0]  col_put;
  logic [ROW_W-1:0]  row_put;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              out_free;

  assign pos     = ADDR_W'(row) * ADDR_W'(SCREEN_COLS) + ADDR_W'(column);
  assign idx_ext = IDX_W'(idx_q);
  assign idx_ok  = idx_ext < IDX_W'(CELL_COUNT);
  assign out_free = !out_valid || !out_stall;

  // Next tab stop: smallest multiple of the tab width above the column
  always_comb begin
    tab_stop = COLX_W'(NUM_STOPS * TAB_WIDTH);
    for (int k = NUM_STOPS; k >= 1; k--) begin
      if (COLX_W'(k * TAB_WIDTH) > COLX_W'(column)) begin
        tab_stop = COLX_W'(k * TAB_WIDTH);
      end
    end
  end

  // Cursor motion for a put request
  always_comb begin
    printable = (char_q >= CH_SPACE) && (char_q <= CH_PRINT_LAST);
    col_x     = COLX_W'(column);
    line_feed = 1'b0;
    put_write = 1'b0;
    unique case (char_q)
      CH_BACKSPACE: begin
        if (column != '0) col_x = COLX_W'(column) - COLX_W'(1);
      end
      CH_TAB: col_x = tab_stop;
      CH_CR:  col_x = '0;
      CH_LF: begin
        col_x     = '0;
        line_feed = 1'b1;
      end
      default: begin
        if (printable) begin
          put_write = 1'b1;
          col_x     = COLX_W'(column) + COLX_W'(1);
        end
      end
    endcase
    wrap       = col_x >= COLX_W'(SCREEN_COLS);
    row_adv    = line_feed || wrap;
    put_scroll = row_adv && (row == ROW_W'(SCREEN_ROWS - 1));
    col_put    = wrap ? '0 : col_x[COL_W-1:0];
    row_put    = (row_adv && !put_scroll) ? row + ROW_W'(1) : row;
  end

  // Memory port selection
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = sweep_addr;
    mem_wdata = {text_attribute, CH_SPACE};
    rd_en     = 1'b0;
    rd_addr   = sweep_addr + ADDR_W'(SCREEN_COLS);
    unique case (cmd.op)
      DP_PUT: begin
        mem_we    = put_write;
        mem_waddr = pos;
        mem_wdata = {text_attribute, char_q};
      end
      DP_READ: begin
        rd_en   = idx_ok;
        rd_addr = idx_ext[ADDR_W-1:0];
      end
      DP_COPY: begin
        rd_en     = 1'b1;
        mem_we    = copy_pend;
        mem_waddr = copy_waddr;
        mem_wdata = rd_data;
      end
      DP_DRAIN: begin
        mem_we    = 1'b1;
        mem_waddr = copy_waddr;
        mem_wdata = rd_data;
      end
      DP_FILL:      mem_we = 1'b1;
      DP_INIT_FILL: begin
        mem_we    = 1'b1;
        mem_wdata = {RESET_ATTR, CH_SPACE};
      end
      default: ;
    endcase
  end

  // Screen memory
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data <= mem[rd_addr];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      text_attribute <= RESET_ATTR;
      column         <= '0;
      row            <= '0;
      sweep_addr     <= '0;
      copy_pend      <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_we) text_attribute <= cfg_wdata;
      // a new result load wins over a taken result in the same cycle
      if (cmd.op == DP_RESULT) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (cmd.op)
        DP_CAPTURE: begin
          sweep_addr <= '0;
          copy_pend  <= 1'b0;
        end
        DP_PUT: begin
          column <= col_put;
          row    <= row_put;
        end
        DP_COPY: begin
          sweep_addr <= sweep_addr + ADDR_W'(1);
          copy_pend  <= 1'b1;
        end
        DP_DRAIN: copy_pend <= 1'b0;
        DP_FILL: begin
          sweep_addr <= sweep_addr + ADDR_W'(1);
          if (cmd.home_cursor) begin
            column <= '0;
            row    <= '0;
          end
        end
        DP_INIT_FILL: sweep_addr <= sweep_addr + ADDR_W'(1);
        default: ;
      endcase
    end
  end

  // Request capture, copy pipeline and output payload
  always_ff @(posedge clk) begin
    if (cmd.op == DP_CAPTURE) begin
      func_q <= func;
      char_q <= char_code;
      idx_q  <= cell_index;
    end
    if (cmd.op == DP_COPY) copy_waddr <= sweep_addr;
    if (cmd.op == DP_RESULT) begin
      cursor_column   <= COL_OUT_W'(column);
      cursor_row_out  <= ROW_OUT_W'(row);
      cursor_location <= LOC_W'(pos);
      cell_word       <= (func_q == FUNC_READ && idx_ok) ? rd_data : '0;
    end
  end

  assign status.func       = func_q;
  assign status.put_scroll = put_scroll;
  assign status.copy_last  = sweep_addr == ADDR_W'(COPY_COUNT - 1);
  assign status.sweep_last = sweep_addr == ADDR_W'(CELL_COUNT - 1);
  assign status.out_free   = out_free;

endmodule

// ----- hdl/tcw_controller.sv -----
// Controller state machine of the text console writer.
// Sequences capture, put, read, scroll copy, drain, fill and result load; depends on tcw_pkg.
module tcw_controller import tcw_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  tcw_status_t status,
  output tcw_cmd_t    cmd
);

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '{op: DP_NOP, home_cursor: 1'b0};
    in_stall   = 1'b1;
    unique case (state)
      ST_INIT: begin
        cmd.op = DP_INIT_FILL;
        if (status.sweep_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.op     = DP_CAPTURE;
          state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (status.func)
          FUNC_PUT: state_next = ST_PUT;
          FUNC_CLEAR: begin
            cmd.op          = DP_FILL;
            cmd.home_cursor = 1'b1;
            state_next      = ST_FILL;
          end
          FUNC_READ: begin
            cmd.op     = DP_READ;
            state_next = ST_DONE;
          end
          default: state_next = ST_DONE;
        endcase
      end
      ST_PUT: begin
        cmd.op     = DP_PUT;
        state_next = status.put_scroll ? ST_COPY : ST_DONE;
      end
      ST_COPY: begin
        cmd.op = DP_COPY;
        if (status.copy_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        cmd.op     = DP_DRAIN;
        state_next = ST_FILL;
      end
      ST_FILL: begin
        cmd.op = DP_FILL;
        if (status.sweep_last) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.op     = DP_RESULT;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_INIT;
    endcase
  end

endmodule

// ----- hdl/tcw_checker.sv -----
// Port-level checks for the text console writer, bound to the top level.
// Depends on tcw_pkg for port widths.
module tcw_checker import tcw_pkg::*; #(
  parameter int SCREEN_COLS = 80,
  parameter int SCREEN_ROWS = 25
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [COL_OUT_W-1:0] cursor_column,
  input logic [ROW_OUT_W-1:0] cursor_row_out,
  input logic [LOC_W-1:0]     cursor_location,
  input logic [CELL_W-1:0]    cell_word
);

  // One request at a time: stall rises right after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted while a previous one is in progress");

  // Reported cursor stays on screen
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (cursor_column < SCREEN_COLS) && (cursor_row_out < SCREEN_ROWS))
    else $error("cursor reported off screen");

  // Linear location agrees with row and column
  a_location: assert property (@(posedge clk) disable iff (rst)
    (out_valid && SCREEN_ROWS <= 32) |->
      cursor_location == LOC_W'(cursor_row_out * SCREEN_COLS + cursor_column))
    else $error("cursor location does not match row and column");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      out_valid && $stable(cursor_location) && $stable(cell_word))
    else $error("stalled result changed");

endmodule

bind text_console_writer tcw_checker #(
  .SCREEN_COLS (SCREEN_COLS),
  .SCREEN_ROWS (SCREEN_ROWS)
) u_tcw_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .cursor_column   (cursor_column),
  .cursor_row_out  (cursor_row_out),
  .cursor_location (cursor_location),
  .cell_word       (cell_word)
);

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking bench for text_console_writer: random put/clear/read requests
// against an in-bench console predictor, with random input idles and output stalls.
// Depends on tcw_pkg for port widths, function codes and character codes.
module tb_top;
  import tcw_pkg::*;

  localparam int COLS  = 80;
  localparam int ROWS  = 25;
  localparam int TABW  = 8;
  localparam int CELLS = COLS * ROWS;

  localparam logic [FUNC_W-1:0] FUNC_NOP_CODE = 2'd3;

  localparam int  ITEM_TARGET   = 1950;
  localparam int  PHASES        = 5;
  localparam int  LONG_HOLD     = 400;
  localparam int  SCROLL_CYCLES = (ROWS - 1) * COLS + COLS + 16;
  localparam longint WATCHDOG_CYCLES =
    3 * (2 * ITEM_TARGET) * (SCROLL_CYCLES + 60 + 60) + 4 * CELLS + 3 * LONG_HOLD;

  typedef struct packed {
    logic [COL_OUT_W-1:0] column;
    logic [ROW_OUT_W-1:0] row;
    logic [LOC_W-1:0]     location;
    logic [CELL_W-1:0]    word;
  } console_report_t;

  // Console predictor plus the queue of reports still owed by the block
  class console_scoreboard;
    logic [CELL_W-1:0] screen [CELLS];
    int unsigned       cur_col;
    int unsigned       cur_row;
    logic [ATTR_W-1:0] attr;
    console_report_t   awaited_reports [$];
    int                failures;

    function void power_on();
      attr     = RESET_ATTR;
      blank_range(0, CELLS);
      cur_col  = 0;
      cur_row  = 0;
      failures = 0;
    endfunction

    function void blank_range(int unsigned from, int unsigned count);
      for (int unsigned i = 0; i < count; i++) screen[from + i] = {attr, CH_SPACE};
    endfunction

    function void set_attribute(logic [ATTR_W-1:0] value);
      attr = value;
    endfunction

    function int unsigned cursor_loc();
      return cur_row * COLS + cur_col;
    endfunction

    function int pending();
      return awaited_reports.size();
    endfunction

    // One put byte: cursor motion, cell write, wrap and scroll
    function void advance_cursor(logic [CHAR_W-1:0] ch);
      if (ch == CH_BACKSPACE) begin
        if (cur_col != 0) cur_col--;
      end else if (ch == CH_TAB) begin
        cur_col = (cur_col / TABW + 1) * TABW;
      end else if (ch == CH_CR) begin
        cur_col = 0;
      end else if (ch == CH_LF) begin
        cur_col = 0;
        cur_row++;
      end else if (ch >= CH_SPACE && ch <= CH_PRINT_LAST) begin
        screen[cur_row * COLS + cur_col] = {attr, ch};
        cur_col++;
      end
      if (cur_col >= COLS) begin
        cur_col = 0;
        cur_row++;
      end
      // past the bottom row: move everything up one row, blank the last
      if (cur_row >= ROWS) begin
        for (int i = 0; i < (ROWS - 1) * COLS; i++) screen[i] = screen[i + COLS];
        blank_range((ROWS - 1) * COLS, COLS);
        cur_row = ROWS - 1;
      end
    endfunction

    function void note_request(logic [FUNC_W-1:0] f, logic [CHAR_W-1:0] ch,
                               logic [INDEX_W-1:0] idx);
      console_report_t rpt;
      int unsigned     loc;
      rpt.word = '0;
      case (f)
        FUNC_PUT: advance_cursor(ch);
        FUNC_CLEAR: begin
          blank_range(0, CELLS);
          cur_col = 0;
          cur_row = 0;
        end
        FUNC_READ: begin
          if (idx < CELLS) rpt.word = screen[idx];
        end
        default: ;
      endcase
      loc          = cursor_loc();
      rpt.column   = cur_col[COL_OUT_W-1:0];
      rpt.row      = cur_row[ROW_OUT_W-1:0];
      rpt.location = loc[LOC_W-1:0];
      awaited_reports.push_back(rpt);
    endfunction

    function void check_result(console_report_t got);
      console_report_t want;
      if (awaited_reports.size() == 0) begin
        $error("result with no request outstanding: col %0d row %0d loc %0d word %h",
               got.column, got.row, got.location, got.word);
        failures++;
        return;
      end
      want = awaited_reports.pop_front();
      if (got.column !== want.column) begin
        $error("cursor_column: expected %0d, actual %0d", want.column, got.column);
        failures++;
      end
      if (got.row !== want.row) begin
        $error("cursor_row_out: expected %0d, actual %0d", want.row, got.row);
        failures++;
      end
      if (got.location !== want.location) begin
        $error("cursor_location: expected %0d, actual %0d", want.location, got.location);
        failures++;
      end
      if (got.word !== want.word) begin
        $error("cell_word: expected %h, actual %h", want.word, got.word);
        failures++;
      end
    endfunction

    function void flush();
      if (awaited_reports.size() != 0) begin
        $error("%0d results never arrived", awaited_reports.size());
        failures++;
      end
    endfunction
  endclass

  logic                 clk        = 1'b0;
  logic                 rst        = 1'b1;
  logic                 cfg_we     = 1'b0;
  logic [ATTR_W-1:0]    cfg_wdata  = '0;
  logic                 in_valid   = 1'b0;
  logic                 in_stall;
  logic [FUNC_W-1:0]    req_func   = '0;
  logic [CHAR_W-1:0]    char_code  = '0;
  logic [INDEX_W-1:0]   cell_index = '0;
  logic                 out_valid;
  logic                 out_stall  = 1'b0;
  logic [COL_OUT_W-1:0] cursor_column;
  logic [ROW_OUT_W-1:0] cursor_row_out;
  logic [LOC_W-1:0]     cursor_location;
  logic [CELL_W-1:0]    cell_word;

  console_scoreboard sb;
  int  sent_count        = 0;
  int  long_hold_cycles  = 0;
  bit  idling_on         = 1'b1;
  longint cycle_count    = 0;

  text_console_writer i_dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .func            (req_func),
    .char_code       (char_code),
    .cell_index      (cell_index),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .cursor_column   (cursor_column),
    .cursor_row_out  (cursor_row_out),
    .cursor_location (cursor_location),
    .cell_word       (cell_word)
  );

  always #6 clk = ~clk;

  // Idle length: mostly none, some short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!idling_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    else if (r < 90) return $urandom_range(1, 3);
    else if (r < 98) return $urandom_range(4, 12);
    else return $urandom_range(20, 60);
  endfunction

  function automatic bit char_ignored(logic [CHAR_W-1:0] ch);
    return !(ch inside {CH_BACKSPACE, CH_TAB, CH_LF, CH_CR}) &&
           (ch < CH_SPACE || ch > CH_PRINT_LAST);
  endfunction

  // Read index: mostly around the cursor, some anywhere, some in the bottom row, some out of range
  function automatic logic [INDEX_W-1:0] pick_read_index();
    int unsigned r;
    int unsigned loc;
    int unsigned back;
    int unsigned pick;
    r    = $urandom_range(0, 99);
    loc  = sb.cursor_loc();
    back = $urandom_range(0, 2);
    if (r < 50) pick = (loc > back) ? loc - back : 0;
    else if (r < 75) pick = $urandom_range(0, CELLS - 1);
    else if (r < 90) pick = $urandom_range((ROWS - 1) * COLS, CELLS - 1);
    else pick = $urandom_range(CELLS, 2047);
    return pick[INDEX_W-1:0];
  endfunction

  function automatic logic [CHAR_W-1:0] pick_control();
    case ($urandom_range(0, 3))
      0:       return CH_BACKSPACE;
      1:       return CH_TAB;
      2:       return CH_CR;
      default: return CH_LF;
    endcase
  endfunction

  // Offer one request, hold it until accepted, then maybe idle
  task automatic send_request(input logic [FUNC_W-1:0] f, input logic [CHAR_W-1:0] ch,
                              input logic [INDEX_W-1:0] idx);
    int unsigned gap;
    in_valid   <= 1'b1;
    req_func   <= f;
    char_code  <= ch;
    cell_index <= idx;
    do @(posedge clk); while (in_stall);
    sb.note_request(f, ch, idx);
    if (!(f == FUNC_PUT && char_ignored(ch))) sent_count++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic put_char(input logic [CHAR_W-1:0] ch);
    send_request(FUNC_PUT, ch, INDEX_W'($urandom_range(0, 2047)));
  endtask

  task automatic read_cell(input logic [INDEX_W-1:0] idx);
    send_request(FUNC_READ, CHAR_W'($urandom_range(0, 255)), idx);
  endtask

  task automatic clear_screen();
    send_request(FUNC_CLEAR, CHAR_W'($urandom_range(0, 255)),
                 INDEX_W'($urandom_range(0, 2047)));
  endtask

  // Stop offering and wait until every report is back and the block is quiet
  task automatic settle_console();
    in_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic load_attribute(input logic [ATTR_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_attribute(value);
  endtask

  // One random burst: text (the most common kind), tabs, newlines, reads, backspaces, a clear or noise
  task automatic run_burst();
    int unsigned kind;
    int unsigned len;
    kind = $urandom_range(0, 99);
    if (kind < 45) begin
      len = $urandom_range(1, 40);
      for (int unsigned i = 0; i < len; i++) begin
        if ($urandom_range(0, 9) == 0) put_char(pick_control());
        else put_char(CHAR_W'($urandom_range(CH_SPACE, CH_PRINT_LAST)));
      end
    end else if (kind < 60) begin
      len = $urandom_range(1, 12);
      for (int unsigned i = 0; i < len; i++) put_char(CH_TAB);
    end else if (kind < 70) begin
      len = $urandom_range(1, 6);
      for (int unsigned i = 0; i < len; i++)
        put_char(($urandom_range(0, 3) == 0) ? CH_CR : CH_LF);
    end else if (kind < 85) begin
      len = $urandom_range(1, 6);
      for (int unsigned i = 0; i < len; i++) read_cell(pick_read_index());
    end else if (kind < 89) begin
      len = $urandom_range(1, 10);
      for (int unsigned i = 0; i < len; i++) put_char(CH_BACKSPACE);
    end else if (kind < 90) begin
      clear_screen();
    end else begin
      len = $urandom_range(1, 4);
      for (int unsigned i = 0; i < len; i++)
        send_request(FUNC_W'($urandom_range(0, 3)), CHAR_W'($urandom_range(0, 255)),
                     INDEX_W'($urandom_range(0, 2047)));
    end
  endtask

  // Result side: check accepted reports, stall at random or on a long hold
  initial begin
    int unsigned     stall_left;
    console_report_t got;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        got = '{cursor_column, cursor_row_out, cursor_location, cell_word};
        sb.check_result(got);
      end
      if (long_hold_cycles > 0) begin
        stall_left       = long_hold_cycles;
        long_hold_cycles = 0;
      end else if (stall_left == 0) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < WATCHDOG_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Main sequence
  initial begin
    logic [ATTR_W-1:0] phase_attr;
    sb = new;
    sb.power_on();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: reset contents, index edges, idle code, byte classes, cursor moves, a clear
    read_cell(11'd0);
    read_cell(INDEX_W'(CELLS - 1));
    read_cell(INDEX_W'(CELLS));
    read_cell(11'h7FF);
    send_request(FUNC_NOP_CODE, 8'hFF, 11'h7FF);
    send_request(FUNC_NOP_CODE, 8'h00, 11'h000);
    put_char(8'h41);
    put_char(CH_PRINT_LAST);
    put_char(CH_SPACE);
    put_char(8'h00);
    put_char(8'h1F);
    put_char(8'h80);
    put_char(8'hFF);
    read_cell(11'd0);
    read_cell(11'd1);
    put_char(CH_BACKSPACE);
    put_char(CH_CR);
    put_char(CH_BACKSPACE);
    put_char(CH_TAB);
    put_char(CH_TAB);
    put_char(CH_LF);
    read_cell(11'd2);
    clear_screen();
    read_cell(11'd0);

    // random phases, each under its own attribute
    for (int p = 0; p < PHASES; p++) begin
      settle_console();
      case (p)
        0:       phase_attr = 8'h00;
        1:       phase_attr = 8'hFF;
        3:       phase_attr = 8'h70;
        default: phase_attr = ATTR_W'($urandom_range(0, 255));
      endcase
      load_attribute(phase_attr);
      idling_on = (p != 3);
      if (p == 1) long_hold_cycles = LONG_HOLD;
      while (sent_count < ITEM_TARGET * (p + 1) / PHASES) run_burst();
    end

    settle_console();
    repeat (60) @(posedge clk);
    sb.flush();
    if (sb.failures == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
